/* design/mec_pkg.sv */
package mec_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned LimitW = 12;
  localparam logic [LimitW-1:0] LimitReset = LimitW'(256);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_MUL,
    ST_SUM,
    ST_RND,
    ST_UPD,
    ST_FIN
  } mec_state_e;

  typedef struct packed {
    logic in_ready;
    logic mul_start;
    logic load_point;
    logic load_sum;
    logic load_rnd;
    logic load_upd;
    logic load_out;
  } mec_ctrl_t;

endpackage

/* design/mec_if.sv */
interface mec_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [mec_pkg::WordW-1:0]   point_real;
  logic signed [mec_pkg::WordW-1:0]   point_imag;

  modport source (output valid, output point_real, output point_imag, input ready);
  modport sink (input valid, input point_real, input point_imag, output ready);
endinterface

interface mec_count_if;
  logic                               valid;
  logic                               ready;
  logic [mec_pkg::LimitW-1:0]         escape_count;

  modport source (output valid, output escape_count, input ready);
  modport sink (input valid, input escape_count, output ready);
endinterface

/* design/mandelbrot_escape_count.sv */
// each iteration passes ST_CHK, ST_MUL, ST_SUM, ST_RND and ST_UPD; an escaping point
// leaves from ST_RND to ST_FIN, and a saturating update leaves from ST_UPD to ST_FIN
// each iteration is bounded by the three bit-serial 32x32 multipliers
// one point at a time; a new point is accepted only once the previous one has left ST_FIN
// the result word is held in an output register, so a point can enter while it waits
// rst_ni clears control state and sets iteration_limit to 256
module mandelbrot_escape_count #(
  parameter int unsigned FRAC_BITS     = 28,
  parameter int unsigned ESCAPE_RADIUS = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mec_pkg::LimitW-1:0]   cfg_data_i,
  mec_point_if.sink                    point_i,
  mec_count_if.source                  count_o
);

  localparam int unsigned W  = mec_pkg::WordW;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned RW = 2 * FRAC_BITS + 5;
  localparam int unsigned CW = (RW > PW) ? RW : PW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned LW = mec_pkg::LimitW;
  localparam logic [CW-1:0] RadiusSq =
    CW'(ESCAPE_RADIUS * ESCAPE_RADIUS) << (2 * FRAC_BITS);
  localparam logic signed [SW-1:0] HalfRe = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] HalfIm = SW'(1) << (FRAC_BITS - 2);
  localparam logic signed [SW-1:0] WordMax = SW'(2147483647);
  localparam logic signed [SW-1:0] WordMin = -(SW'(2147483647)) - SW'(1);

  mec_pkg::mec_state_e state_q, state_d;
  mec_pkg::mec_ctrl_t  ctrl;

  logic [LW-1:0]         limit_q, cnt_q;
  logic signed [W-1:0]   c_re_q, c_im_q, z_re_q, z_im_q;
  logic [W-1:0]          mag_re, mag_im;
  logic                  neg_q;
  logic [PW-1:0]         rr, ii, ri;
  logic                  mul_done, done_ii, done_ri;
  logic [PW-1:0]         sum_q;
  logic signed [SW-1:0]  diff_q, rim_q, rd_q, rdi_q, nr, ni;
  logic                  escaped, sat;
  logic signed [W-1:0]   nr_c, ni_c;
  logic                  out_valid_q;
  logic [LW-1:0]         out_cnt_q;

  assign mag_re = z_re_q[W-1] ? W'(-z_re_q) : W'(z_re_q);
  assign mag_im = z_im_q[W-1] ? W'(-z_im_q) : W'(z_im_q);

  mec_serial_mul #(.W(W)) u_mul_rr (
    .clk_i, .rst_ni, .start_i(ctrl.mul_start), .a_i(mag_re), .b_i(mag_re),
    .prod_o(rr), .done_o(mul_done)
  );
  mec_serial_mul #(.W(W)) u_mul_ii (
    .clk_i, .rst_ni, .start_i(ctrl.mul_start), .a_i(mag_im), .b_i(mag_im),
    .prod_o(ii), .done_o(done_ii)
  );
  mec_serial_mul #(.W(W)) u_mul_ri (
    .clk_i, .rst_ni, .start_i(ctrl.mul_start), .a_i(mag_re), .b_i(mag_im),
    .prod_o(ri), .done_o(done_ri)
  );

  assign escaped = CW'(sum_q) >= RadiusSq;

  assign nr = rd_q + SW'(c_re_q);
  assign ni = rdi_q + SW'(c_im_q);

  always_comb begin
    sat  = 1'b0;
    nr_c = W'(nr);
    ni_c = W'(ni);
    if (nr > WordMax) begin
      nr_c = W'(WordMax);
      sat  = 1'b1;
    end else if (nr < WordMin) begin
      nr_c = W'(WordMin);
      sat  = 1'b1;
    end
    if (ni > WordMax) begin
      ni_c = W'(WordMax);
      sat  = 1'b1;
    end else if (ni < WordMin) begin
      ni_c = W'(WordMin);
      sat  = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mec_pkg::ST_IDLE: if (point_i.valid) state_d = mec_pkg::ST_CHK;
      mec_pkg::ST_CHK:  state_d = (cnt_q < limit_q) ? mec_pkg::ST_MUL : mec_pkg::ST_FIN;
      mec_pkg::ST_MUL:  if (mul_done) state_d = mec_pkg::ST_SUM;
      mec_pkg::ST_SUM:  state_d = mec_pkg::ST_RND;
      mec_pkg::ST_RND:  state_d = escaped ? mec_pkg::ST_FIN : mec_pkg::ST_UPD;
      mec_pkg::ST_UPD:  state_d = sat ? mec_pkg::ST_FIN : mec_pkg::ST_CHK;
      mec_pkg::ST_FIN:  if (!out_valid_q || count_o.ready) state_d = mec_pkg::ST_IDLE;
      default:          state_d = mec_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      mec_pkg::ST_IDLE: begin
        ctrl.in_ready   = 1'b1;
        ctrl.load_point = point_i.valid;
      end
      mec_pkg::ST_CHK:  ctrl.mul_start = cnt_q < limit_q;
      mec_pkg::ST_MUL:  ctrl.load_sum  = mul_done;
      mec_pkg::ST_SUM:  ctrl.load_rnd  = 1'b1;
      mec_pkg::ST_RND:  ctrl.load_upd  = 1'b0;
      mec_pkg::ST_UPD:  ctrl.load_upd  = 1'b1;
      mec_pkg::ST_FIN:  ctrl.load_out  = !out_valid_q || count_o.ready;
      default:          ctrl = '0;
    endcase
  end

  assign point_i.ready      = ctrl.in_ready;
  assign count_o.valid      = out_valid_q;
  assign count_o.escape_count = out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mec_pkg::ST_IDLE;
      limit_q     <= mec_pkg::LimitReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (ctrl.load_point) cnt_q <= '0;
      else if (ctrl.load_upd) cnt_q <= cnt_q + LW'(1);
      if (ctrl.load_out) out_valid_q <= 1'b1;
      else if (count_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_point) begin
      c_re_q <= point_i.point_real;
      c_im_q <= point_i.point_imag;
      z_re_q <= '0;
      z_im_q <= '0;
    end else if (ctrl.load_upd) begin
      z_re_q <= nr_c;
      z_im_q <= ni_c;
    end
    if (ctrl.mul_start) neg_q <= z_re_q[W-1] ^ z_im_q[W-1];
    if (ctrl.load_sum) begin
      sum_q  <= rr + ii;
      diff_q <= $signed({1'b0, rr}) - $signed({1'b0, ii});
      rim_q  <= neg_q ? -$signed({1'b0, ri}) : $signed({1'b0, ri});
    end
    if (ctrl.load_rnd) begin
      rd_q  <= (diff_q + HalfRe) >>> FRAC_BITS;
      rdi_q <= (rim_q + HalfIm) >>> (FRAC_BITS - 1);
    end
    if (ctrl.load_out) out_cnt_q <= cnt_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != mec_pkg::ST_IDLE |-> cnt_q <= limit_q)
    else $error("count passed the iteration limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == mec_pkg::ST_MUL && done_ii && done_ri)
    else $error("multiplier finished outside the multiply phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mec_pkg::ST_UPD && sat |=> state_q == mec_pkg::ST_FIN)
    else $error("saturated point kept iterating");

endmodule

/* design/mec_serial_mul.sv */
module mec_serial_mul #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] prod_o,
  output logic           done_o
);

  localparam int unsigned CntW = $clog2(W) + 1;

  logic [W-1:0]    hi_q, lo_q, a_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [W:0]      psum;

  // one multiplier bit per cycle, partial sum shifts right
  assign psum = {1'b0, hi_q} + {1'b0, (lo_q[0] ? a_q : '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
      a_q  <= a_i;
    end else if (run_q) begin
      hi_q <= psum[W:1];
      lo_q <= {psum[0], lo_q[W-1:1]};
    end
  end

  assign prod_o = {hi_q, lo_q};
  assign done_o = done_q;

endmodule

/* tb/mec_checker.sv */
`timescale 1ns / 1ps
module mec_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mec_pkg::LimitW-1:0] cfg_data_i,
  mec_point_if                       pt,
  mec_count_if                       cnt,
  output int                         fail_count,
  output int                         pending_count
);

  localparam int unsigned FracBits = 28;
  localparam longint unsigned RadiusSqWide = 64'd4 << (2 * FracBits);
  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -64'sd2147483648;

  logic [mec_pkg::LimitW-1:0] limit_q;
  logic [mec_pkg::LimitW-1:0] expected_counts[$];

  function automatic logic [mec_pkg::LimitW-1:0] escape_iterations(
    input logic signed [31:0] c_re,
    input logic signed [31:0] c_im,
    input logic [mec_pkg::LimitW-1:0] lim
  );
    longint zr, zi, rr, ii, ri, nr, ni;
    logic [63:0] mag_sq;
    int unsigned n;
    bit sat;
    zr = 0;
    zi = 0;
    n = 0;
    sat = 0;
    while (n < lim && !sat) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      mag_sq = rr + ii;
      if (mag_sq >= RadiusSqWide) break;
      nr = ((rr - ii + (64'sd1 <<< (FracBits - 1))) >>> FracBits) + longint'(c_re);
      ni = ((ri + (64'sd1 <<< (FracBits - 2))) >>> (FracBits - 1)) + longint'(c_im);
      if (nr > WordMax) begin
        sat = 1; zr = WordMax;
      end else if (nr < WordMin) begin
        sat = 1; zr = WordMin;
      end else begin
        zr = nr;
      end
      if (ni > WordMax) begin
        sat = 1; zi = WordMax;
      end else if (ni < WordMin) begin
        sat = 1; zi = WordMin;
      end else begin
        zi = ni;
      end
      n++;
    end
    return n[mec_pkg::LimitW-1:0];
  endfunction

  initial fail_count = 0;
  initial pending_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic [mec_pkg::LimitW-1:0] want;
    if (!rst_ni) begin
      limit_q = mec_pkg::LimitReset;
      expected_counts.delete();
    end else begin
      if (cnt.valid && cnt.ready) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected word, escape_count %0d", $time, cnt.escape_count);
          fail_count++;
        end else begin
          want = expected_counts.pop_front();
          if (cnt.escape_count !== want) begin
            $display("%0t: escape_count expected %0d actual %0d", $time, want,
                     cnt.escape_count);
            fail_count++;
          end
        end
      end
      if (pt.valid && pt.ready)
        expected_counts.push_back(escape_iterations(pt.point_real, pt.point_imag, limit_q));
      if (cfg_we_i) limit_q = cfg_data_i;
    end
    pending_count = expected_counts.size();
  end

endmodule

/* tb/tb_mandelbrot_escape_count.sv */
`timescale 1ns / 1ps
module tb_mandelbrot_escape_count;

  localparam int WatchdogLimit = 1000000;
  localparam logic signed [31:0] OneQ = 32'sh1000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mec_pkg::LimitW-1:0] cfg_data_i = '0;
  bit no_idle = 1'b0;
  int fail_count, pending_count, quiet_cycles;

  mec_point_if pt ();
  mec_count_if cnt ();

  mandelbrot_escape_count dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .point_i(pt), .count_o(cnt)
  );

  mec_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .pt(pt), .cnt(cnt), .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    pt.valid = 1'b0;
    pt.point_real = '0;
    pt.point_imag = '0;
    cnt.ready = 1'b0;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) cnt.ready <= 1'b1;
    else if (r < 3) cnt.ready <= 1'b0;
    else if (r < 25) cnt.ready <= cnt.ready ^ 1'b1;
    else cnt.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if ((pt.valid && pt.ready) || (cnt.valid && cnt.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("mandelbrot_escape_count test failed");
      $finish;
    end
  end

  task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im);
    int gap, r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      pt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pt.valid <= 1'b1;
    pt.point_real <= re;
    pt.point_imag <= im;
    do @(posedge clk_i); while (!pt.ready);
  endtask

  task automatic drain();
    pt.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [mec_pkg::LimitW-1:0] lim);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom();
    if (r < 4) return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
  endfunction

  task automatic random_points(input int n);
    repeat (n) begin
      if ($urandom_range(0, 199) == 0) no_idle = ~no_idle;
      send_point(pick_coord(), pick_coord());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_point(0, 0);
    send_point(-2 * OneQ, 0);
    send_point(-OneQ, 0);
    send_point(OneQ >>> 2, 0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7fff_ffff, 0);
    send_point(32'sh8000_0000, 0);
    send_point(0, 32'sh8000_0000);
    send_point(0, 32'sh7fff_ffff);
    send_point(2 * OneQ, 2 * OneQ);
    send_point(-(OneQ >>> 2) * 3, OneQ >>> 3);
    send_point(0, OneQ);
    set_limit(0);
    send_point(0, 0);
    send_point(32'sh7fff_ffff, 32'sh8000_0000);
    random_points(20);
    set_limit(1);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    random_points(60);
    set_limit(4095);
    send_point(0, 0);
    send_point(-2 * OneQ, 0);
    send_point(OneQ, OneQ);
    set_limit(31);
    random_points(400);
    drain();
    random_points(400);
    set_limit(64);
    random_points(300);
    set_limit(256);
    random_points(140);
    drain();
    if (fail_count == 0) begin
      $display("mandelbrot_escape_count test passed");
    end else begin
      $display("mandelbrot_escape_count test failed");
    end
    $finish;
  end

endmodule

/* mandelbrot_escape_count.f */
design/mec_pkg.sv
design/mec_if.sv
design/mec_serial_mul.sv
design/mandelbrot_escape_count.sv
tb/mec_checker.sv
tb/tb_mandelbrot_escape_count.sv
